// ===== rtl/core/dlp_pkg.sv =====
// ----------------------------------------------------------------------------
// dlp_pkg
// Shared constants and types for the longest-path layering block.
// ----------------------------------------------------------------------------
package dlp_pkg;

	localparam int DefMaxVertices = 64;
	localparam int DefMaxEdges    = 256;
	localparam int OutLimit       = 64;
	localparam int VtxW           = 6;
	localparam int CountW         = 7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CYCLE   = 2'd1;
	localparam logic [1:0] ST_OVERFLW = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	localparam logic FUNC_EDGE    = 1'b0;
	localparam logic FUNC_COMPUTE = 1'b1;

endpackage

// ===== rtl/core/dag_longest_path_level_weights.sv =====
// ----------------------------------------------------------------------------
// dag_longest_path_level_weights
// Longest-path layering of a small DAG held in on-chip memories.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// in       in   valid / stall  func, left_vertex, right_vertex, left_greater
// out      out  valid / stall  vertex_index, weight, status, last
// cfg      in   cfg_we         cfg_wdata (vertex_count)
//
// A compute runs relaxation passes over the edge memory, each edge in three
// steps (read, level read, write back), at most n-1 passes plus 1 check
// pass; then a max scan over the levels, then a setup step and one result
// per cycle while the output is not stalled. The edge step is the
// read-modify-write loop on the level memory. Reset clears control state and
// the level valid bits. Results stall in the output register; input stalls
// while a run is busy.
// ----------------------------------------------------------------------------
module dag_longest_path_level_weights
	import dlp_pkg::*;
#(
	parameter int MaxVertices = DefMaxVertices,
	parameter int MaxEdges    = DefMaxEdges
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [VtxW-1:0]   left_vertex,
	input  logic [VtxW-1:0]   right_vertex,
	input  logic              left_greater,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VtxW-1:0]   vertex_index,
	output logic [VtxW-1:0]   weight,
	output logic [1:0]        status,
	output logic              last
);

	localparam int AddrW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
	localparam int TotW  = $clog2(MaxEdges + 1);
	localparam int IdxW  = $clog2(MaxVertices);
	localparam int Lim   = (MaxVertices < OutLimit) ? MaxVertices : OutLimit;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ERD   = 7'b0000010,
		S_LRD   = 7'b0000100,
		S_UPD   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_CYC   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CountW-1:0] vcount_q;
	logic [TotW-1:0]   etotal_q;
	logic [1:0]        eflags_q;
	logic [TotW-1:0]   eidx_q;
	logic [CountW-1:0] pass_q;
	logic              changed_q;
	logic [CountW-1:0] vi_q;
	logic [VtxW-1:0]   top_q;
	logic [1:0]        st_q;
	logic [CountW-1:0] n_eff;

	logic              ov_q;
	logic [VtxW-1:0]   ov_idx_q, ov_w_q;
	logic [1:0]        ov_st_q;
	logic              ov_last_q;
	logic              ov_load;

	// effective vertex count
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = CountW'(1);
		end else if (32'(vcount_q) > Lim) begin
			n_eff = CountW'(Lim);
		end else begin
			n_eff = vcount_q;
		end
	end

	logic in_acc, out_free;
	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign ov_load  = out_free && ((state_q == S_EMIT && vi_q != '0) || state_q == S_CYC);

	// edge memory
	logic [VtxW-1:0]   src_v, dst_v;
	logic              l_ok, r_ok, e_wr;
	logic [2*VtxW-1:0] e_rd;
	assign l_ok  = 32'(left_vertex) < 32'(n_eff);
	assign r_ok  = 32'(right_vertex) < 32'(n_eff);
	assign src_v = left_greater ? left_vertex : right_vertex;
	assign dst_v = left_greater ? right_vertex : left_vertex;
	assign e_wr  = in_acc && func == FUNC_EDGE && l_ok && r_ok
		&& 32'(etotal_q) < MaxEdges;

	dlp_edge_mem #(.MaxEdges(MaxEdges), .AddrW(AddrW)) u_edges (
		.clk     (clk),
		.wr_en   (e_wr),
		.wr_addr (etotal_q[AddrW-1:0]),
		.wr_data ({src_v, dst_v}),
		.rd_addr (eidx_q[AddrW-1:0]),
		.rd_data (e_rd)
	);

	// level memory
	logic [VtxW-1:0] ea, eb, la, lb;
	logic            lv_clr, lv_wr, e_use;
	logic [IdxW-1:0] ra_addr, rb_addr;
	assign ea    = e_rd[2*VtxW-1:VtxW];
	assign eb    = e_rd[VtxW-1:0];
	assign lv_clr = in_acc && func == FUNC_COMPUTE;
	assign e_use  = 32'(ea) < 32'(n_eff) && 32'(eb) < 32'(n_eff);
	logic [VtxW-1:0] eb_s1;
	logic            use_s1;
	assign lv_wr = (state_q == S_UPD) && use_s1 && ({1'b0, lb} < {1'b0, la} + 1'b1);
	assign ra_addr = (state_q == S_SCAN) ? IdxW'(vi_q) : IdxW'(ea);

	// emit read: next vertex when the slot moves on, same vertex while held
	logic [CountW-1:0] emit_rd;
	assign emit_rd = (out_free || vi_q == '0) ? vi_q : vi_q - 1'b1;
	assign rb_addr = (state_q == S_EMIT) ? IdxW'(emit_rd) : IdxW'(eb);

	dlp_level_mem #(.MaxVertices(MaxVertices), .IdxW(IdxW)) u_levels (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (lv_clr),
		.wr_en     (lv_wr),
		.wr_addr   (IdxW'(eb_s1)),
		.wr_data   (la + 1'b1),
		.rd_addr_a (ra_addr),
		.rd_data_a (la),
		.rd_addr_b (rb_addr),
		.rd_data_b (lb)
	);

	// sequencer
	logic pass_end;
	assign pass_end = (eidx_q + 1'b1 >= etotal_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vcount_q  <= CountW'(1);
			etotal_q  <= '0;
			eflags_q  <= '0;
			eidx_q    <= '0;
			pass_q    <= '0;
			changed_q <= 1'b0;
			vi_q      <= '0;
			top_q     <= '0;
			st_q      <= ST_OK;
			ov_q      <= 1'b0;
			ov_idx_q  <= '0;
			ov_w_q    <= '0;
			ov_st_q   <= ST_OK;
			ov_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (ov_load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && func == FUNC_EDGE) begin
						if (!(l_ok && r_ok)) begin
							eflags_q[0] <= 1'b1;
						end else if (32'(etotal_q) >= MaxEdges) begin
							eflags_q[1] <= 1'b1;
						end else begin
							etotal_q <= etotal_q + 1'b1;
						end
					end else if (in_acc) begin
						st_q      <= eflags_q[0] ? ST_RANGE
							: (eflags_q[1] ? ST_OVERFLW : ST_OK);
						eflags_q  <= '0;
						eidx_q    <= '0;
						pass_q    <= '0;
						changed_q <= 1'b0;
						vi_q      <= '0;
						top_q     <= '0;
						state_q   <= (etotal_q == '0) ? S_SCAN : S_ERD;
					end
				end
				S_ERD: state_q <= S_LRD;
				S_LRD: state_q <= S_UPD;
				S_UPD: begin
					if (lv_wr && !pass_end) begin
						changed_q <= 1'b1;
					end
					if (!pass_end) begin
						eidx_q  <= eidx_q + 1'b1;
						state_q <= S_ERD;
					end else begin
						eidx_q    <= '0;
						changed_q <= 1'b0;
						if (32'(pass_q) + 1 >= 32'(n_eff)) begin
							// check pass: a change means a cycle
							if (changed_q || lv_wr) begin
								if (32'(pass_q) + 1 == 32'(n_eff)) begin
									state_q <= S_CYC;
								end else begin
									pass_q  <= pass_q + 1'b1;
									state_q <= S_ERD;
								end
							end else begin
								state_q <= S_SCAN;
							end
						end else if (changed_q || lv_wr) begin
							pass_q  <= pass_q + 1'b1;
							state_q <= S_ERD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// la is registered, so it holds the level of the previous vertex index
					if (vi_q != '0 && la > top_q) begin
						top_q <= la;
					end
					if (vi_q == n_eff) begin
						vi_q    <= '0;
						state_q <= S_EMIT;
					end else begin
						vi_q <= vi_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free && vi_q != '0) begin
						ov_idx_q  <= VtxW'(vi_q - 1'b1);
						ov_w_q    <= top_q - lb;
						ov_st_q   <= st_q;
						ov_last_q <= (vi_q == n_eff);
						if (vi_q == n_eff) begin
							etotal_q <= '0;
							state_q  <= S_IDLE;
						end else begin
							vi_q <= vi_q + 1'b1;
						end
					end else if (vi_q == '0) begin
						vi_q <= vi_q + 1'b1;
					end
				end
				S_CYC: begin
					if (out_free) begin
						ov_idx_q  <= '0;
						ov_w_q    <= '0;
						ov_st_q   <= ST_CYCLE;
						ov_last_q <= 1'b1;
						etotal_q  <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// edge pipeline stage
	always_ff @(posedge clk) begin
		if (state_q == S_LRD) begin
			eb_s1  <= eb;
			use_s1 <= e_use;
		end
	end

	assign out_valid    = ov_q;
	assign vertex_index = ov_idx_q;
	assign weight       = ov_w_q;
	assign status       = ov_st_q;
	assign last         = ov_last_q;

endmodule

// ===== rtl/core/dlp_edge_mem.sv =====
// ----------------------------------------------------------------------------
// dlp_edge_mem
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlp_edge_mem
	import dlp_pkg::*;
#(
	parameter int MaxEdges = DefMaxEdges,
	parameter int AddrW    = (MaxEdges > 1) ? $clog2(MaxEdges) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AddrW-1:0]    wr_addr,
	input  logic [2*VtxW-1:0]   wr_data,
	input  logic [AddrW-1:0]    rd_addr,
	output logic [2*VtxW-1:0]   rd_data
);

	logic [2*VtxW-1:0] mem [MaxEdges];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/dlp_level_mem.sv =====
// ----------------------------------------------------------------------------
// dlp_level_mem
// Vertex level store: two registered read ports, one write port.
// Entries not marked valid read as zero.
// ----------------------------------------------------------------------------
module dlp_level_mem
	import dlp_pkg::*;
#(
	parameter int MaxVertices = DefMaxVertices,
	parameter int IdxW        = $clog2(MaxVertices)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             wr_en,
	input  logic [IdxW-1:0]  wr_addr,
	input  logic [VtxW-1:0]  wr_data,
	input  logic [IdxW-1:0]  rd_addr_a,
	output logic [VtxW-1:0]  rd_data_a,
	input  logic [IdxW-1:0]  rd_addr_b,
	output logic [VtxW-1:0]  rd_data_b
);

	logic [VtxW-1:0]        mem [MaxVertices];
	logic [MaxVertices-1:0] vld_q;
	logic [VtxW-1:0]        raw_a, raw_b;
	logic                   va_q, vb_q;

	// valid bits, cleared at once at each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_a <= mem[rd_addr_a];
		raw_b <= mem[rd_addr_b];
		va_q  <= vld_q[rd_addr_a] & ~clear;
		vb_q  <= vld_q[rd_addr_b] & ~clear;
	end

	assign rd_data_a = va_q ? raw_a : '0;
	assign rd_data_b = vb_q ? raw_b : '0;

endmodule

// ===== rtl/core/dlp_checker.sv =====
// ----------------------------------------------------------------------------
// dlp_checker
// Port-level checks of the layering block.
// ----------------------------------------------------------------------------
module dlp_checker
	import dlp_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [VtxW-1:0] vertex_index,
	input logic [VtxW-1:0] weight,
	input logic [1:0]      status,
	input logic            last
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_index) && $stable(weight))
		else $error("stalled result changed");

	// a cycle result is the lone, final one
	a_cyc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CYCLE |-> last && vertex_index == '0 && weight == '0)
		else $error("bad cycle result");

	// a non-final result is followed by the next vertex
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last ##1 out_valid |-> vertex_index == $past(vertex_index) + 1'b1)
		else $error("vertex order broken");

	// input is not taken while results are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && out_valid && !last |-> in_stall)
		else $error("input accepted mid run");

endmodule

bind dag_longest_path_level_weights dlp_checker u_dlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.vertex_index (vertex_index),
	.weight       (weight),
	.status       (status),
	.last         (last)
);
